// ===== rtl/core/dtpc_pkg.sv =====
// ----------------------------------------------------------------------------
// dtpc_pkg
// Shared types and constants of the differential temperature pump controller.
// ----------------------------------------------------------------------------
package dtpc_pkg;

    localparam int NOW_W          = 32;
    localparam int TEMP_W         = 12;
    localparam int TEMP_DIFF_W    = 11;
    localparam int RUN_SECONDS_W  = 16;
    localparam int INTERVAL_W     = 8;

    localparam int IN_TDATA_W     = 48;   // 32 + 12, padded to bytes
    localparam int OUT_TDATA_W    = 32;   // 4 flags + 2 x 12, padded to bytes

    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_TEMP_DIFF   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RUN_SECONDS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL    = 2'd2;

    localparam logic [TEMP_DIFF_W-1:0]   TEMP_DIFF_RST   = 11'd80;
    localparam logic [RUN_SECONDS_W-1:0] RUN_SECONDS_RST = 16'd600;
    localparam logic [INTERVAL_W-1:0]    INTERVAL_RST    = 8'd5;

    localparam logic SENSOR_ROOF = 1'b0;
    localparam logic SENSOR_POOL = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic capture;     // request accepted: latch time and reading
        logic record;      // store reading, advance position, clear sums
        logic accum;       // add one window entry
        logic div_start;   // load divider
        logic div_step;    // one quotient bit
        logic commit;      // update state and result register
    } dtpc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic act;         // interval elapsed for the held request
        logic acc_last;    // last window entry being added
        logic div_last;    // last quotient bit being formed
    } dtpc_stat_t;

endpackage

// ===== rtl/core/dtpc_dp.sv =====
// ----------------------------------------------------------------------------
// dtpc_dp
// Datapath: config registers, sensor windows, sum/count sweep, restoring
// divider and pump decision.
// ----------------------------------------------------------------------------
module dtpc_dp #(
    parameter int WINDOW_DEPTH = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [dtpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dtpc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [dtpc_pkg::NOW_W-1:0]          now_seconds,
    input  logic signed [dtpc_pkg::TEMP_W-1:0]  temperature,
    input  dtpc_pkg::dtpc_cmd_t                 cmd,
    output dtpc_pkg::dtpc_stat_t                stat,
    output logic [dtpc_pkg::OUT_TDATA_W-1:0]    result
);
    import dtpc_pkg::*;

    localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = TEMP_W + $clog2(WINDOW_DEPTH);
    localparam int BIT_W = $clog2(SUM_W);

    logic [TEMP_DIFF_W-1:0]   temp_diff_reg;
    logic [RUN_SECONDS_W-1:0] run_seconds_reg;
    logic [INTERVAL_W-1:0]    interval_reg;

    logic [NOW_W-1:0]         now_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic                     act_reg;

    logic signed [TEMP_W-1:0] roof_win_reg [WINDOW_DEPTH];
    logic signed [TEMP_W-1:0] pool_win_reg [WINDOW_DEPTH];
    logic [IDX_W-1:0]         roof_pos_reg;
    logic [IDX_W-1:0]         pool_pos_reg;
    logic                     sel_reg;
    logic signed [TEMP_W-1:0] roof_avg_reg;
    logic signed [TEMP_W-1:0] pool_avg_reg;
    logic                     pump_on_reg;
    logic [NOW_W-1:0]         start_stamp_reg;
    logic [NOW_W-1:0]         last_action_reg;

    logic [SUM_W-1:0]         sum_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [CNT_W-1:0]         rem_reg;
    logic [SUM_W-1:0]         quot_reg;
    logic [BIT_W-1:0]         bit_reg;
    logic [OUT_TDATA_W-1:0]   result_reg;

    logic signed [TEMP_W-1:0] entry;
    logic                     entry_pos;
    logic [IDX_W-1:0]         cur_pos;
    logic [IDX_W-1:0]         pos_adv;
    logic [CNT_W:0]           trial;
    logic                     trial_ge;
    logic signed [TEMP_W-1:0] avg_new;
    logic signed [TEMP_W-1:0] roof_upd;
    logic signed [TEMP_W-1:0] pool_upd;
    logic signed [TEMP_W:0]   diff;
    logic                     start_ok;
    logic                     stop_ok;
    logic                     pump_upd;
    logic                     changed;
    logic [NOW_W-1:0]         elapsed;

    assign entry     = (sel_reg == SENSOR_POOL) ? pool_win_reg[idx_reg] : roof_win_reg[idx_reg];
    assign entry_pos = !entry[TEMP_W-1] && (entry != '0);

    assign cur_pos = (sel_reg == SENSOR_POOL) ? pool_pos_reg : roof_pos_reg;
    assign pos_adv = (cur_pos == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : cur_pos + IDX_W'(1);

    assign trial    = {rem_reg, quot_reg[SUM_W-1]};
    assign trial_ge = trial >= {1'b0, count_reg};

    assign elapsed = now_seconds - last_action_reg;

    always_comb
    begin
        avg_new  = (count_reg == '0) ? temp_reg : $signed(quot_reg[TEMP_W-1:0]);
        roof_upd = roof_avg_reg;
        pool_upd = pool_avg_reg;
        if (act_reg)
        begin
            if (sel_reg == SENSOR_POOL)
                pool_upd = avg_new;
            else
                roof_upd = avg_new;
        end
        diff     = {roof_upd[TEMP_W-1], roof_upd} - {pool_upd[TEMP_W-1], pool_upd};
        start_ok = (roof_upd != '0) && (pool_upd != '0)
                   && (diff >= $signed({2'b00, temp_diff_reg}));
        stop_ok  = (now_reg - start_stamp_reg) > {{(NOW_W-RUN_SECONDS_W){1'b0}}, run_seconds_reg};
        pump_upd = pump_on_reg;
        changed  = 1'b0;
        if (act_reg)
        begin
            if (pump_on_reg)
            begin
                if (stop_ok)
                begin
                    pump_upd = 1'b0;
                    changed  = 1'b1;
                end
            end
            else if (start_ok)
            begin
                pump_upd = 1'b1;
                changed  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_diff_reg   <= TEMP_DIFF_RST;
            run_seconds_reg <= RUN_SECONDS_RST;
            interval_reg    <= INTERVAL_RST;
            act_reg         <= 1'b0;
            for (int i = 0; i < WINDOW_DEPTH; i++)
            begin
                roof_win_reg[i] <= '0;
                pool_win_reg[i] <= '0;
            end
            roof_pos_reg    <= '0;
            pool_pos_reg    <= '0;
            sel_reg         <= SENSOR_ROOF;
            roof_avg_reg    <= '0;
            pool_avg_reg    <= '0;
            pump_on_reg     <= 1'b0;
            start_stamp_reg <= '0;
            last_action_reg <= '0;
            count_reg       <= '0;
            idx_reg         <= '0;
            bit_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TEMP_DIFF:   temp_diff_reg   <= cfg_data[TEMP_DIFF_W-1:0];
                    CFG_RUN_SECONDS: run_seconds_reg <= cfg_data[RUN_SECONDS_W-1:0];
                    CFG_INTERVAL:    interval_reg    <= cfg_data[INTERVAL_W-1:0];
                    default:         ;
                endcase
            end

            if (cmd.capture)
                act_reg <= elapsed >= {{(NOW_W-INTERVAL_W){1'b0}}, interval_reg};

            if (cmd.record)
            begin
                if (sel_reg == SENSOR_POOL)
                begin
                    pool_win_reg[pool_pos_reg] <= temp_reg;
                    pool_pos_reg               <= pos_adv;
                end
                else
                begin
                    roof_win_reg[roof_pos_reg] <= temp_reg;
                    roof_pos_reg               <= pos_adv;
                end
                count_reg <= '0;
                idx_reg   <= '0;
            end

            if (cmd.accum)
            begin
                if (entry_pos)
                    count_reg <= count_reg + CNT_W'(1);
                if (!stat.acc_last)
                    idx_reg <= idx_reg + IDX_W'(1);
            end

            if (cmd.div_start)
                bit_reg <= '0;
            if (cmd.div_step)
                bit_reg <= bit_reg + BIT_W'(1);

            if (cmd.commit && act_reg)
            begin
                last_action_reg <= now_reg;
                roof_avg_reg    <= roof_upd;
                pool_avg_reg    <= pool_upd;
                sel_reg         <= !sel_reg;
                pump_on_reg     <= pump_upd;
                if (changed && pump_upd)
                    start_stamp_reg <= now_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            now_reg  <= now_seconds;
            temp_reg <= temperature;
        end
        if (cmd.record)
            sum_reg <= '0;
        if (cmd.accum && entry_pos)
            sum_reg <= sum_reg + {{(SUM_W-TEMP_W+1){1'b0}}, entry[TEMP_W-2:0]};
        if (cmd.div_start)
        begin
            rem_reg  <= '0;
            quot_reg <= sum_reg;
        end
        if (cmd.div_step)
        begin
            rem_reg  <= trial_ge ? CNT_W'(trial - {1'b0, count_reg}) : trial[CNT_W-1:0];
            quot_reg <= {quot_reg[SUM_W-2:0], trial_ge};
        end
        if (cmd.commit)
        begin
            result_reg <= {4'b0000, pool_upd, roof_upd,
                           act_reg ? !sel_reg : sel_reg, pump_upd, changed, act_reg};
        end
    end

    assign stat.act      = act_reg;
    assign stat.acc_last = idx_reg == IDX_W'(WINDOW_DEPTH - 1);
    assign stat.div_last = bit_reg == BIT_W'(SUM_W - 1);
    assign result        = result_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(WINDOW_DEPTH))
        else $error("positive entry count exceeds window depth");

    a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && act_reg && count_reg != '0) |-> (quot_reg[SUM_W-1:TEMP_W-1] == '0))
        else $error("window average out of range");
`endif

endmodule

// ===== rtl/core/dtpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtpc_ctrl
// Sequencer: accept, interval check, window sweep, divide, commit, and the
// result handshake.
// ----------------------------------------------------------------------------
module dtpc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  dtpc_pkg::dtpc_stat_t  stat,
    output dtpc_pkg::dtpc_cmd_t   cmd
);
    import dtpc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SUM,
        ST_DIV_INIT,
        ST_DIV,
        ST_COMMIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.act)
                begin
                    cmd.record = 1'b1;
                    state_next = ST_SUM;
                end
                else
                    state_next = ST_COMMIT;
            end
            ST_SUM:
            begin
                cmd.accum = 1'b1;
                if (stat.acc_last)
                    state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                cmd.commit     = 1'b1;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_CHECK))
        else $error("accepted request not followed by interval check");

    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT) |=> m_tvalid)
        else $error("commit did not raise result valid");

    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("ready raised while a request is in progress");
`endif

endmodule

// ===== rtl/core/differential_temp_pump_controller.sv =====
// Steps: accept, interval check and commit when the interval has not elapsed;
//   when it acts, accept, interval check, window sweep over WINDOW_DEPTH entries,
//   divider load, bit-serial divide of SUM_W quotient bits (SUM_W = 12 +
//   clog2(WINDOW_DEPTH)) and commit. No new request is accepted until the last
//   commits; a held result does not stop the next one being accepted once it is being taken.
// Reset (rst_n, async, active low): state clears, config returns to 80 / 600 / 5.
// ----------------------------------------------------------------------------
// differential_temp_pump_controller
// Solar pool pump controller driven by alternate roof/pool readings.
// ----------------------------------------------------------------------------
module differential_temp_pump_controller #(
    parameter int WINDOW_DEPTH = 10
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [dtpc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [dtpc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // now_seconds[31:0], temperature[43:32], zero pad
    input  logic [dtpc_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // acted[0], changed[1], pump_running[2], next_sensor[3],
    // roof_average[15:4], pool_average[27:16], zero pad
    output logic [dtpc_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import dtpc_pkg::*;

    dtpc_cmd_t  cmd;
    dtpc_stat_t stat;

    dtpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dtpc_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .now_seconds (s_tdata[NOW_W-1:0]),
        .temperature ($signed(s_tdata[NOW_W+TEMP_W-1:NOW_W])),
        .cmd         (cmd),
        .stat        (stat),
        .result      (m_tdata)
    );

endmodule
